// ===== rtl/core/bthac_pkg.sv =====
// Shared types, constants and codes of the boundary-tag heap allocator.
package bthac_pkg;

  localparam int unsigned HeapBytesDef = 65536;
  localparam int unsigned AddrSpan     = 65536;
  localparam int unsigned BaW          = 18;   // byte address width
  localparam int unsigned TagW         = 17;   // tag word width
  localparam int unsigned CfgW         = 17;

  localparam logic [TagW-1:0] LimitRst = 17'd65536;
  localparam logic [TagW-1:0] ChunkRst = 17'd4096;
  localparam logic [BaW-1:0]  MinBlock = 18'd16;

  // Configuration register indexes.
  localparam logic CfgHeapLimit = 1'b0;
  localparam logic CfgGrowChunk = 1'b1;

  // Answer codes.
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNull = 2'd1;
  localparam logic [1:0] StOom  = 2'd2;

  // One access to the tag memory.
  typedef struct packed {
    logic            we;
    logic [BaW-1:0]  addr;
    logic [TagW-1:0] wdata;
  } bthac_mreq_t;

endpackage

// ===== rtl/core/bthac_agu.sv =====
// Shared address unit: every tag address is base plus span minus a tag offset.
module bthac_agu import bthac_pkg::*; (
  input  logic [BaW-1:0] base_i,
  input  logic [BaW-1:0] span_i,
  input  logic [3:0]     back_i,
  output logic [BaW-1:0] addr_o
);

  // One adder and one subtractor, reused by every state of the sequencer.
  assign addr_o = base_i + span_i - {{(BaW-4){1'b0}}, back_i};

endmodule

// ===== rtl/core/bthac_tagmem.sv =====
// Tag memory: one 17-bit word per 4 heap bytes, one access per cycle.
module bthac_tagmem import bthac_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HeapBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bthac_mreq_t     req_i,
  output logic [TagW-1:0] rdata_o
);

  localparam int unsigned Words = HEAP_BYTES / 4;
  localparam int unsigned Aw    = $clog2(Words);

  logic [TagW-1:0] mem [Words];
  logic [31:0]     word;
  logic [Aw-1:0]   idx;
  logic            in_range;
  logic [TagW-1:0] rd_q;
  logic            rd_ok_q;

  // Word address; anything beyond the store reads as zero and drops writes.
  assign word     = {{(32-BaW+2){1'b0}}, req_i.addr[BaW-1:2]};
  assign in_range = word < Words;
  assign idx      = word[Aw-1:0];

  // Storage array with registered read data.
  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      mem[idx] <= req_i.wdata;
    end
    rd_q <= mem[idx];
  end

  // Range flag of the last read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= in_range;
    end
  end

  assign rdata_o = rd_ok_q ? rd_q : '0;

endmodule

// ===== rtl/core/boundary_tag_heap_allocator_core.sv =====
// Top level: sequencer that walks and edits the boundary tags of the heap.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o   mode_i, request_size_i, block_addr_i
//  out      output     out_valid_o/out_stall_i result_addr_o, status_o
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// An allocate walks the blocks of the heap for the best fit, then grows, merges and
// splits as needed; a free walks the blocks up to its address, then marks and merges.
// Every step goes through the single tag memory port.
// After reset the heap is built before the first item is taken.
// A result waiting under out_stall_i holds back only the end of the next item.
module boundary_tag_heap_allocator_core import bthac_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HeapBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  logic [15:0]     request_size_i,
  input  logic [15:0]     block_addr_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [15:0]     result_addr_o,
  output logic [1:0]      status_o
);

  localparam int unsigned LimCap = (HEAP_BYTES < AddrSpan) ? HEAP_BYTES : AddrSpan;
  localparam logic [TagW-1:0] SizeMask = 17'h1FFF8;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_IDLE,
    S_BF_RD, S_BF_CHK, S_GR, S_GR_W1, S_GR_W2, S_GR_W3,
    S_CO_R1, S_CO_R2, S_CO_R3, S_CO_R4, S_CO_R5, S_CO_W1, S_CO_W2,
    S_CV_RD, S_CV_CHK, S_CV_W1, S_CV_W2, S_CV_W3, S_CV_W4, S_CV_W5, S_CV_W6,
    S_FR_RD, S_FR_CHK, S_FR_W1, S_FR_W2, S_DONE
  } state_e;

  typedef enum logic [1:0] {C_INIT, C_ALLOC, C_FREE} caller_e;

  state_e          state_q;
  caller_e         caller_q;
  logic [TagW-1:0] limit_q, chunk_q;
  logic [BaW-1:0]  bp_q, brk_q, need_q, size_q, best_q, best_sz_q, ext_q, total_q;
  logic [BaW-1:0]  prev_bp_q, addr_q;
  logic            found_q, pused_q, nused_q;
  logic [1:0]      st_q;
  logic [BaW-1:0]  res_q;
  logic            out_valid_q;
  logic [15:0]     out_addr_q;
  logic [1:0]      out_st_q;

  logic [BaW-1:0]  ag_base, ag_span, ag_addr;
  logic [3:0]      ag_back;
  bthac_mreq_t     mreq;
  logic [TagW-1:0] rdata;
  logic [BaW-1:0]  rd_size;
  logic            rd_used;
  logic [BaW-1:0]  lim;
  logic [BaW:0]    gsize, gtop;
  logic [BaW-1:0]  need_new, co_size;

  bthac_agu u_agu (
    .base_i (ag_base),
    .span_i (ag_span),
    .back_i (ag_back),
    .addr_o (ag_addr)
  );

  bthac_tagmem #(.HEAP_BYTES(HEAP_BYTES)) u_tagmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // Fields of the tag just read.
  assign rd_size = {1'b0, rdata & SizeMask};
  assign rd_used = rdata[0];

  // Limit in force and growth size rounded to the nearest double word, halves up.
  assign lim   = ({1'b0, limit_q} < BaW'(LimCap)) ? {1'b0, limit_q} : BaW'(LimCap);
  assign gsize = ({1'b0, ext_q} + (BaW+1)'(4)) & ~(BaW+1)'(7);
  assign gtop  = {1'b0, brk_q} + gsize;
  assign need_new = (request_size_i <= 16'd8) ? MinBlock
                  : (({2'b0, request_size_i} + BaW'(15)) & ~BaW'(7));
  assign co_size = size_q + (nused_q ? '0 : total_q);

  // Address and write data of the tag access in each state.
  always_comb begin
    ag_base = bp_q;
    ag_span = '0;
    ag_back = 4'd4;
    mreq.we    = 1'b0;
    mreq.wdata = '0;
    case (state_q)
      S_INIT0: begin ag_base = '0; ag_back = 4'd0; mreq.we = 1'b1; end
      S_INIT1: begin ag_base = BaW'(4); ag_back = 4'd0; mreq.we = 1'b1;
                     mreq.wdata = 17'd9; end
      S_INIT2: begin ag_base = BaW'(8); ag_back = 4'd0; mreq.we = 1'b1;
                     mreq.wdata = 17'd9; end
      S_INIT3: begin ag_base = BaW'(12); ag_back = 4'd0; mreq.we = 1'b1;
                     mreq.wdata = 17'd1; end
      S_GR_W1: begin mreq.we = 1'b1; mreq.wdata = size_q[TagW-1:0]; end
      S_GR_W2: begin ag_span = size_q; ag_back = 4'd8; mreq.we = 1'b1;
                     mreq.wdata = size_q[TagW-1:0]; end
      S_GR_W3: begin ag_span = size_q; mreq.we = 1'b1; mreq.wdata = 17'd1; end
      S_CO_R1: ag_back = 4'd8;
      S_CO_R3: ag_span = rd_size;
      S_CO_R4: ag_base = prev_bp_q;
      S_CO_W1: begin mreq.we = 1'b1; mreq.wdata = size_q[TagW-1:0]; end
      S_CO_W2: begin ag_span = size_q; ag_back = 4'd8; mreq.we = 1'b1;
                     mreq.wdata = size_q[TagW-1:0]; end
      S_CV_W1: begin mreq.we = 1'b1; mreq.wdata = need_q[TagW-1:0] | 17'd1; end
      S_CV_W2: begin ag_span = need_q; ag_back = 4'd8; mreq.we = 1'b1;
                     mreq.wdata = need_q[TagW-1:0] | 17'd1; end
      S_CV_W3: begin ag_span = need_q; mreq.we = 1'b1;
                     mreq.wdata = TagW'(total_q - need_q); end
      S_CV_W4: begin ag_span = total_q; ag_back = 4'd8; mreq.we = 1'b1;
                     mreq.wdata = TagW'(total_q - need_q); end
      S_CV_W5: begin mreq.we = 1'b1; mreq.wdata = total_q[TagW-1:0] | 17'd1; end
      S_CV_W6: begin ag_span = total_q; ag_back = 4'd8; mreq.we = 1'b1;
                     mreq.wdata = total_q[TagW-1:0] | 17'd1; end
      S_FR_W1: begin mreq.we = 1'b1; mreq.wdata = size_q[TagW-1:0]; end
      S_FR_W2: begin ag_span = size_q; ag_back = 4'd8; mreq.we = 1'b1;
                     mreq.wdata = size_q[TagW-1:0]; end
      default: ;
    endcase
    mreq.addr = ag_addr;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_addr_q;
  assign status_o      = out_st_q;

  // Sequencer, configuration registers and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT0;
      caller_q    <= C_INIT;
      limit_q     <= LimitRst;
      chunk_q     <= ChunkRst;
      brk_q       <= '0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_st_q    <= StOk;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgHeapLimit: limit_q <= cfg_data_i;
          CfgGrowChunk: chunk_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT0: state_q <= S_INIT1;
        S_INIT1: state_q <= S_INIT2;
        S_INIT2: state_q <= S_INIT3;
        S_INIT3: begin
          brk_q    <= BaW'(16);
          ext_q    <= {1'b0, chunk_q};
          caller_q <= C_INIT;
          state_q  <= S_GR;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            res_q <= '0;
            bp_q  <= BaW'(8);
            addr_q <= {2'b0, block_addr_i};
            found_q <= 1'b0;
            need_q  <= need_new;
            if (!mode_i) begin
              caller_q <= C_ALLOC;
              if (request_size_i == '0) begin
                st_q <= StNull;
                state_q <= S_DONE;
              end else begin
                st_q <= StOk;
                state_q <= S_BF_RD;
              end
            end else begin
              caller_q <= C_FREE;
              if (block_addr_i == '0) begin
                st_q <= StNull;
                state_q <= S_DONE;
              end else begin
                st_q <= StOk;
                state_q <= S_FR_RD;
              end
            end
          end
        end
        // Best-fit walk over the block chain.
        S_BF_RD: state_q <= S_BF_CHK;
        S_BF_CHK: begin
          if (rd_size == '0) begin
            if (found_q) begin
              bp_q    <= best_q;
              state_q <= S_CV_RD;
            end else begin
              ext_q   <= (need_q > {1'b0, chunk_q}) ? need_q : {1'b0, chunk_q};
              state_q <= S_GR;
            end
          end else begin
            if (!rd_used && rd_size >= need_q && (!found_q || rd_size < best_sz_q)) begin
              found_q   <= 1'b1;
              best_q    <= bp_q;
              best_sz_q <= rd_size;
            end
            bp_q    <= bp_q + rd_size;
            state_q <= S_BF_RD;
          end
        end
        // Heap growth at the break.
        S_GR: begin
          if (gsize == '0 || gtop > {1'b0, lim}) begin
            st_q    <= StOom;
            state_q <= (caller_q == C_INIT) ? S_IDLE : S_DONE;
          end else begin
            bp_q    <= brk_q;
            size_q  <= gsize[BaW-1:0];
            brk_q   <= gtop[BaW-1:0];
            state_q <= S_GR_W1;
          end
        end
        S_GR_W1: state_q <= S_GR_W2;
        S_GR_W2: state_q <= S_GR_W3;
        S_GR_W3: state_q <= S_CO_R1;
        // Merging with free neighbours.
        S_CO_R1: state_q <= S_CO_R2;
        S_CO_R2: begin
          pused_q   <= rd_used;
          prev_bp_q <= bp_q - rd_size;
          state_q   <= S_CO_R3;
        end
        S_CO_R3: begin
          size_q  <= rd_size;
          state_q <= S_CO_R4;
        end
        S_CO_R4: begin
          nused_q <= rd_used;
          total_q <= rd_size;
          if (pused_q && rd_used) begin
            state_q <= (caller_q == C_ALLOC) ? S_CV_RD
                     : (caller_q == C_FREE) ? S_DONE : S_IDLE;
          end else begin
            state_q <= pused_q ? S_CO_W1 : S_CO_R5;
            // Only the next block merges here; the other path adds it below.
            if (pused_q) begin
              size_q <= size_q + (rd_used ? '0 : rd_size);
            end
          end
        end
        S_CO_R5: begin
          size_q  <= co_size + rd_size;
          bp_q    <= prev_bp_q;
          state_q <= S_CO_W1;
        end
        S_CO_W1: state_q <= S_CO_W2;
        S_CO_W2: begin
          state_q <= (caller_q == C_ALLOC) ? S_CV_RD
                   : (caller_q == C_FREE) ? S_DONE : S_IDLE;
        end
        // Marking the chosen block and, if it is large enough, splitting off the remainder.
        S_CV_RD: state_q <= S_CV_CHK;
        S_CV_CHK: begin
          total_q <= rd_size;
          res_q   <= bp_q;
          state_q <= (rd_size >= need_q + MinBlock) ? S_CV_W1 : S_CV_W5;
        end
        S_CV_W1: state_q <= S_CV_W2;
        S_CV_W2: state_q <= S_CV_W3;
        S_CV_W3: state_q <= S_CV_W4;
        S_CV_W4: state_q <= S_DONE;
        S_CV_W5: state_q <= S_CV_W6;
        S_CV_W6: state_q <= S_DONE;
        // Walk to the block being freed, then mark it free.
        S_FR_RD: begin
          if (bp_q > addr_q) begin
            st_q    <= StNull;
            state_q <= S_DONE;
          end else begin
            state_q <= S_FR_CHK;
          end
        end
        S_FR_CHK: begin
          if (rd_size == '0) begin
            st_q    <= StNull;
            state_q <= S_DONE;
          end else if (bp_q == addr_q) begin
            size_q <= rd_size;
            if (bp_q >= MinBlock && rd_used) begin
              state_q <= S_FR_W1;
            end else begin
              st_q    <= StNull;
              state_q <= S_DONE;
            end
          end else begin
            bp_q    <= bp_q + rd_size;
            state_q <= S_FR_RD;
          end
        end
        S_FR_W1: state_q <= S_FR_W2;
        S_FR_W2: state_q <= S_CO_R1;
        // Hand the result to the output register.
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_addr_q  <= res_q[15:0];
            out_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The break always stays double-word aligned.
  a_brk_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q[2:0] == 3'd0) else $error("heap break misaligned");

  // The break never passes the largest possible heap.
  a_brk_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= BaW'(LimCap)) else $error("heap break beyond capacity");

  // An accepted item makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("item not taken up");

  // A result appears only on leaving the final state.
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE)) else $error("stray result");

endmodule

// ===== dv/boundary_tag_heap_allocator_core_test.sv =====
// Self-checking testbench of the boundary-tag heap allocator core.
module boundary_tag_heap_allocator_core_test;
  import bthac_pkg::*;

  localparam int unsigned TagWords = HeapBytesDef / 4;
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;
  localparam logic [1:0] StAny = 2'd3;  // table marker: result left to the heap model

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_stall_o;
  logic            mode_i;
  logic [15:0]     request_size_i;
  logic [15:0]     block_addr_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [15:0]     result_addr_o;
  logic [1:0]      status_o;

  boundary_tag_heap_allocator_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .request_size_i (request_size_i),
    .block_addr_i   (block_addr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_addr_o  (result_addr_o),
    .status_o       (status_o)
  );

  // One answer of the allocator.
  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } answer_t;

  // One row of the directed table.
  typedef struct packed {
    logic        mode;
    logic [15:0] size;
    logic [15:0] addr;
    logic [15:0] want_addr;
    logic [1:0]  want_status;
  } row_t;

  // Heap model state.
  logic [16:0] tags[TagWords];
  logic [16:0] brk;
  logic [16:0] limit_reg;
  logic [16:0] chunk_reg;

  answer_t     answers_due[$];
  logic [15:0] live_blocks[$];
  int          errors;
  bit          idle_on;
  bit          hold_off;

  // Clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [16:0] tag_rd(logic [17:0] a);
    return (a[17:2] < TagWords) ? tags[a[17:2]] : 17'd0;
  endfunction

  function automatic void tag_wr(logic [17:0] a, logic [16:0] v);
    if (a[17:2] < TagWords) tags[a[17:2]] = v;
  endfunction

  function automatic logic [17:0] size_at(logic [17:0] bp);
    return {1'b0, tag_rd(bp - 18'd4) & 17'h1fff8};
  endfunction

  function automatic logic used_at(logic [17:0] bp);
    logic [16:0] t;
    t = tag_rd(bp - 18'd4);
    return t[0];
  endfunction

  function automatic void mark(logic [17:0] bp, logic [17:0] sz, logic u);
    tag_wr(bp - 18'd4, sz[16:0] | {16'd0, u});
    tag_wr(bp + sz - 18'd8, sz[16:0] | {16'd0, u});
  endfunction

  function automatic logic [17:0] merge(logic [17:0] bp);
    logic [17:0] sz;
    logic        pu;
    logic [17:0] pbp;
    logic [17:0] nbp;
    logic        nu;
    logic [16:0] pt;
    sz  = size_at(bp);
    pt  = tag_rd(bp - 18'd8);
    pu  = pt[0];
    pbp = bp - {1'b0, pt & 17'h1fff8};
    nbp = bp + sz;
    nu  = used_at(nbp);
    if (pu && nu) return bp;
    if (!nu) sz += size_at(nbp);
    if (!pu) begin
      sz += size_at(pbp);
      bp = pbp;
    end
    mark(bp, sz, 1'b0);
    return bp;
  endfunction

  function automatic logic [16:0] lim_eff();
    return (limit_reg > 17'd65536) ? 17'd65536 : limit_reg;
  endfunction

  function automatic logic [17:0] extend(logic [17:0] bytes);
    logic [17:0] sz;
    logic [17:0] bp;
    sz = bytes[2] ? ((bytes & ~18'd3) + 18'd4) : (bytes & ~18'd3);
    if (sz == 0 || {1'b0, brk} + sz > {1'b0, lim_eff()}) return 18'd0;
    bp = {1'b0, brk};
    brk = brk + sz[16:0];
    mark(bp, sz, 1'b0);
    tag_wr(bp + sz - 18'd4, 17'd1);
    return merge(bp);
  endfunction

  function automatic void heap_reset();
    foreach (tags[i]) tags[i] = '0;
    limit_reg = LimitRst;
    chunk_reg = ChunkRst;
    tags[1] = 17'd9;
    tags[2] = 17'd9;
    tags[3] = 17'd1;
    brk = 17'd16;
    void'(extend({1'b0, chunk_reg}));
  endfunction

  // Predicts the answer of one request and updates the heap model.
  function automatic answer_t heap_request(logic m, logic [15:0] req, logic [15:0] a);
    answer_t     ans;
    logic [17:0] need;
    logic [17:0] bp;
    logic [17:0] best;
    logic [17:0] s;
    logic [18:0] best_sz;
    logic [17:0] total;
    logic        found;
    ans = '{addr: 16'd0, status: StOk};
    if (m == ModeAlloc) begin
      if (req == 0) begin
        ans.status = StNull;
      end else begin
        need = (req <= 8) ? 18'd16 : (({2'b0, req} + 18'd15) & ~18'd7);
        best = 0;
        best_sz = '1;
        bp = 18'd8;
        while (bp < 18'h20000) begin
          s = size_at(bp);
          if (s == 0) break;
          if (!used_at(bp) && s >= need && {1'b0, s} < best_sz) begin
            best = bp;
            best_sz = {1'b0, s};
          end
          bp += s;
        end
        if (best == 0) best = extend((need > chunk_reg) ? need : {1'b0, chunk_reg});
        if (best == 0) begin
          ans.status = StOom;
        end else begin
          total = size_at(best);
          if (total >= need + MinBlock) begin
            mark(best, need, 1'b1);
            mark(best + need, total - need, 1'b0);
          end else begin
            mark(best, total, 1'b1);
          end
          ans.addr = best[15:0];
        end
      end
    end else begin
      found = 1'b0;
      bp = 18'd8;
      while (bp < 18'h20000 && bp <= a) begin
        s = size_at(bp);
        if (s == 0) break;
        if (bp == a) begin
          found = bp >= MinBlock && used_at(bp);
          break;
        end
        bp += s;
      end
      if (a == 0 || !found) begin
        ans.status = StNull;
      end else begin
        mark({2'b0, a}, size_at({2'b0, a}), 1'b0);
        void'(merge({2'b0, a}));
      end
    end
    return ans;
  endfunction

  task automatic report(string what, answer_t got, answer_t want);
    $display("mismatch %s: got addr %0d status %0d, want addr %0d status %0d",
             what, got.addr, got.status, want.addr, want.status);
    errors++;
  endtask

  // Sends one item, then queues its predicted answer.
  task automatic send(logic m, logic [15:0] sz, logic [15:0] a, answer_t typed);
    answer_t pred;
    @(posedge clk_i);
    while (idle_on && $urandom_range(99) < 20) @(posedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    request_size_i <= sz;
    block_addr_i   <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    pred = heap_request(m, sz, a);
    if (typed.status != StAny && pred != typed) report("table vs model", pred, typed);
    if (m == ModeAlloc && pred.status == StOk) live_blocks.push_back(pred.addr);
    answers_due.push_back(pred);
  endtask

  task automatic drain();
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [16:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgHeapLimit) limit_reg = v;
    else chunk_reg = v;
  endtask

  // Random traffic: mostly allocates and frees of live blocks.
  task automatic random_phase(int n, int max_size);
    int          k;
    int          pick;
    logic [15:0] a;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send(ModeAlloc, (pick < 3) ? 16'($urandom) : 16'($urandom_range(max_size)), '0,
             '{'0, StAny});
      end else if (pick < 85 && live_blocks.size() != 0) begin
        k = k;
        pick = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[pick];
        live_blocks.delete(pick);
        send(ModeFree, 16'($urandom), a, '{'0, StAny});
      end else begin
        a = (pick < 95 && live_blocks.size() != 0) ?
            live_blocks[0] + 16'($urandom_range(1, 15)) : 16'($urandom);
        send(ModeFree, 16'($urandom), a, '{'0, StAny});
      end
    end
  endtask

  // Result side: random stall and in-order checking.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          report("unexpected answer", '{result_addr_o, status_o}, '0);
        end else begin
          if (result_addr_o !== answers_due[0].addr || status_o !== answers_due[0].status)
            report("answer", '{result_addr_o, status_o}, answers_due[0]);
          void'(answers_due.pop_front());
        end
      end
      out_stall_i <= idle_on && ($urandom_range(99) < 20);
    end
  end

  // Directed table, then random traffic over several register settings.
  row_t directed[] = '{
    '{ModeAlloc, 16'd0,     16'd0,   16'd0,  StNull},
    '{ModeAlloc, 16'd1,     16'd0,   16'd16, StOk},
    '{ModeAlloc, 16'd8,     16'd0,   16'd32, StOk},
    '{ModeAlloc, 16'd9,     16'd0,   16'd48, StOk},
    '{ModeFree,  16'd0,     16'd0,   16'd0,  StNull},
    '{ModeFree,  16'hffff,  16'd17,  16'd0,  StNull},
    '{ModeFree,  16'd0,     16'd8,   16'd0,  StNull},
    '{ModeFree,  16'd0,     16'hffff,16'd0,  StNull},
    '{ModeFree,  16'd0,     16'd32,  16'd0,  StOk},
    '{ModeFree,  16'd0,     16'd32,  16'd0,  StNull},
    '{ModeAlloc, 16'hffff,  16'd0,   16'd0,  StOom},
    '{ModeAlloc, 16'd4000,  16'd0,   16'd0,  StAny},
    '{ModeAlloc, 16'd8,     16'd0,   16'd0,  StAny},
    '{ModeFree,  16'd0,     16'd16,  16'd0,  StOk},
    '{ModeFree,  16'd0,     16'd48,  16'd0,  StOk},
    '{ModeAlloc, 16'd30000, 16'd0,   16'd0,  StAny},
    '{ModeAlloc, 16'd32000, 16'd0,   16'd0,  StAny},
    '{ModeAlloc, 16'haaaa,  16'h5555,16'd0,  StAny}
  };

  initial begin
    errors      = 0;
    idle_on     = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgHeapLimit;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mode_i      = ModeAlloc;
    request_size_i = '0;
    block_addr_i   = '0;
    heap_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i])
      send(directed[i].mode, directed[i].size, directed[i].addr,
           '{directed[i].want_addr, directed[i].want_status});
    random_phase(200, 300);
    idle_on = 1'b1;
    random_phase(250, 2000);
    drain();
    // Small heap, smallest growth.
    write_reg(CfgHeapLimit, 17'd2048);
    write_reg(CfgGrowChunk, 17'd16);
    random_phase(250, 200);
    drain();
    // Odd growth step, full limit.
    write_reg(CfgHeapLimit, 17'h1ffff);
    write_reg(CfgGrowChunk, 17'd20);
    random_phase(250, 1000);
    drain();
    // Largest growth chunk, limit at its lowest.
    write_reg(CfgGrowChunk, 17'd65536);
    write_reg(CfgHeapLimit, 17'd32);
    random_phase(60, 64);
    drain();
    write_reg(CfgHeapLimit, 17'd65536);
    write_reg(CfgGrowChunk, 17'd512);
    random_phase(200, 4000);
    drain();
    if (errors == 0) $display("boundary_tag_heap_allocator_core_test: done, clean");
    else $display("boundary_tag_heap_allocator_core_test: done, errors");
    $finish;
  end

  // Watchdog.
  initial begin
    #400000000;
    $display("boundary_tag_heap_allocator_core_test: done, errors");
    $finish;
  end

endmodule

// ===== boundary_tag_heap_allocator_core.f =====
rtl/core/bthac_pkg.sv
rtl/core/bthac_agu.sv
rtl/core/bthac_tagmem.sv
rtl/core/boundary_tag_heap_allocator_core.sv
dv/boundary_tag_heap_allocator_core_test.sv
